### hdl/lscs_pkg.sv
// ----------------------------------------------------------------------------
// lscs_pkg: shared types and constants for the line sensor centroid steer unit
// Holds the controller-to-datapath command word, field widths, register
// indexes and the drive table reset values.
// ----------------------------------------------------------------------------
package lscs_pkg;

  localparam int LANES_MAX  = 8;   // sample ports on the input word
  localparam int SAMPLE_W   = 8;   // width of one sample port
  localparam int POS_W      = 4;   // line position width
  localparam int DRIVE_W    = 8;   // one drive byte
  localparam int IDX_W      = 3;   // table entry index
  localparam int CFG_W      = 64;  // widest configuration register
  localparam int CFG_IDX_W  = 1;   // configuration register index
  localparam int SCALE_W    = 7;   // scaled value 0..100
  localparam int CNT_W      = 3;   // step counter

  localparam int unsigned FULL_SCALE = 100;

  localparam logic [IDX_W-1:0]     TABLE_TOP = 3'd7;
  localparam logic [CNT_W-1:0]     DIV_LAST  = 3'(SCALE_W - 1);
  localparam logic [CNT_W-1:0]     CDIV_LAST = 3'(POS_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 1'd1;

  localparam logic [CFG_W-1:0] LEFT_RESET  = 64'h0000_7882_A0D2_E6FA;
  localparam logic [CFG_W-1:0] RIGHT_RESET = 64'hF0C8_BE96_8264_0000;

  typedef struct packed {
    logic capture;    // take the input word, widen the extremes
    logic load;       // set up the per-lane dividers
    logic div_step;   // one quotient bit in every lane
    logic sum;        // form total and weighted sums, set up centroid divider
    logic cdiv_step;  // one quotient bit of the centroid
    logic out_load;   // fill the output register
  } lscs_cmd_t;

endpackage

### hdl/lscs_ctrl.sv
// ----------------------------------------------------------------------------
// lscs_ctrl: sequencing controller
// Steps the datapath through capture, lane divide, sum, centroid divide and
// output load; owns the handshake flags.
// ----------------------------------------------------------------------------
module lscs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_calibrate,
  input  logic                out_stall,
  output logic                in_stall,
  output logic                out_valid,
  output lscs_pkg::lscs_cmd_t cmd
);
  import lscs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_CDIV = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid && !in_calibrate) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SUM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = CDIV_LAST;
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        cmd.cdiv_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/lscs_datapath.sv
// ----------------------------------------------------------------------------
// lscs_datapath: per-lane extremes, scaling dividers and centroid divider
// Holds the calibration extremes, one restoring divider per lane, the
// weighted sum, the centroid divider, the drive tables and the output word.
// ----------------------------------------------------------------------------
module lscs_datapath #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lscs_pkg::lscs_cmd_t               cmd,
  input  logic [lscs_pkg::SAMPLE_W-1:0]     samples [lscs_pkg::LANES_MAX],
  input  logic                              cfg_we,
  input  logic [lscs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lscs_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [lscs_pkg::POS_W-1:0]        line_position,
  output logic [lscs_pkg::DRIVE_W-1:0]      left_drive,
  output logic [lscs_pkg::DRIVE_W-1:0]      right_drive,
  output logic                              no_line
);
  import lscs_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int NUM_W    = SB + SCALE_W;
  localparam int TOT_W    = $clog2(FULL_SCALE * CHANNELS + 1);
  localparam int WGT_W    = $clog2(FULL_SCALE * CHANNELS * (CHANNELS + 1) / 2 + 1);
  localparam int CQ_SHIFT = POS_W - 1;
  localparam int CW       = (WGT_W > TOT_W + CQ_SHIFT) ? WGT_W : TOT_W + CQ_SHIFT;

  logic [SB-1:0]      s_r     [CHANNELS];
  logic [SB-1:0]      peak_r  [CHANNELS];
  logic [SB-1:0]      floor_r [CHANNELS];
  logic               zspan_r [CHANNELS];
  logic [NUM_W-1:0]   rem_r   [CHANNELS];
  logic [NUM_W-1:0]   dsh_r   [CHANNELS];
  logic [SCALE_W-1:0] q_r     [CHANNELS];
  logic [SCALE_W-1:0] scaled  [CHANNELS];

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    logic [15:0]      s_ext;
    logic [SB-1:0]    s_in, span, diff;
    logic [NUM_W-1:0] num, dinit;
    logic             ge;

    always_comb begin
      s_ext = {8'b0, samples[k]};
      s_in  = s_ext[SB-1:0];
      span  = peak_r[k] - floor_r[k];
      diff  = s_r[k] - floor_r[k];
      num   = NUM_W'(diff) * NUM_W'(FULL_SCALE);
      dinit = NUM_W'(span) << (SCALE_W - 1);
      ge    = (rem_r[k] >= dsh_r[k]);
      if (zspan_r[k]) begin
        scaled[k] = '0;
      end else if (q_r[k] > SCALE_W'(FULL_SCALE)) begin
        scaled[k] = SCALE_W'(FULL_SCALE);
      end else begin
        scaled[k] = q_r[k];
      end
    end

    // extremes are block state: reset to an empty range
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        peak_r[k]  <= '0;
        floor_r[k] <= '1;
      end else if (cmd.capture) begin
        if (s_in > peak_r[k])  peak_r[k]  <= s_in;
        if (s_in < floor_r[k]) floor_r[k] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        s_r[k] <= s_in;
      end
      if (cmd.load) begin
        rem_r[k]   <= num;
        dsh_r[k]   <= dinit;
        zspan_r[k] <= (span == '0);
        q_r[k]     <= '0;
      end else if (cmd.div_step) begin
        if (ge) rem_r[k] <= rem_r[k] - dsh_r[k];
        dsh_r[k] <= dsh_r[k] >> 1;
        q_r[k]   <= {q_r[k][SCALE_W-2:0], ge};
      end
    end
  end

  logic [TOT_W-1:0] tot;
  logic [WGT_W-1:0] wgt;

  always_comb begin
    tot = '0;
    wgt = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      tot = tot + TOT_W'(scaled[k]);
      wgt = wgt + WGT_W'(k + 1) * WGT_W'(scaled[k]);
    end
  end

  logic [CW-1:0]    crem_r, cdsh_r;
  logic [POS_W-1:0] cq_r;
  logic             nol_r;
  logic             cge;

  assign cge = (crem_r >= cdsh_r);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      crem_r <= CW'(wgt);
      cdsh_r <= CW'(tot) << CQ_SHIFT;
      cq_r   <= '0;
      nol_r  <= (tot == '0);
    end else if (cmd.cdiv_step) begin
      if (cge) crem_r <= crem_r - cdsh_r;
      cdsh_r <= cdsh_r >> 1;
      cq_r   <= {cq_r[POS_W-2:0], cge};
    end
  end

  logic [CFG_W-1:0] left_tab_r, right_tab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_tab_r  <= LEFT_RESET;
      right_tab_r <= RIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT:  left_tab_r  <= cfg_wdata;
        REG_RIGHT: right_tab_r <= cfg_wdata;
      endcase
    end
  end

  logic [POS_W-1:0] pos_c;
  logic [IDX_W-1:0] idx;

  always_comb begin
    pos_c = nol_r ? '0 : cq_r;
    idx   = (pos_c > POS_W'(TABLE_TOP)) ? TABLE_TOP : pos_c[IDX_W-1:0];
  end

  logic [POS_W-1:0]   pos_r;
  logic [DRIVE_W-1:0] left_r, right_r;
  logic               no_line_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_r     <= pos_c;
      left_r    <= left_tab_r[idx*DRIVE_W +: DRIVE_W];
      right_r   <= right_tab_r[idx*DRIVE_W +: DRIVE_W];
      no_line_r <= nol_r;
    end
  end

  assign line_position = pos_r;
  assign left_drive    = left_r;
  assign right_drive   = right_r;
  assign no_line       = no_line_r;

endmodule

### hdl/line_sensor_centroid_steer_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_centroid_steer_unit: line sensor calibration, centroid, steering
// A frame word runs load, the 7-step per-lane scaling divider, the sum, the
// 4-step centroid divider and the output load, one after the other under the
// controller; no new frame word is taken until its result is loaded.
// A calibration word is taken every cycle while the controller is idle.
// Reset (rst_n low, synchronous): extremes cleared, drive tables to defaults.
// ----------------------------------------------------------------------------
module line_sensor_centroid_steer_unit #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel: one sensor frame per word
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_calibrate,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_0,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_1,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_2,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_3,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_4,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_5,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_6,
  input  logic [lscs_pkg::SAMPLE_W-1:0]  in_sample_7,
  // result channel: one steering word per non-calibration frame
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lscs_pkg::POS_W-1:0]     out_line_position,
  output logic [lscs_pkg::DRIVE_W-1:0]   out_left_drive,
  output logic [lscs_pkg::DRIVE_W-1:0]   out_right_drive,
  output logic                           out_no_line,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lscs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lscs_pkg::CFG_W-1:0]     cfg_wdata
);
  import lscs_pkg::*;

  lscs_cmd_t           cmd;
  logic [SAMPLE_W-1:0] samples [LANES_MAX];

  // Gather the sample ports into lanes; lanes beyond CHANNELS are dropped
  // inside the datapath.
  always_comb begin
    samples[0] = in_sample_0;
    samples[1] = in_sample_1;
    samples[2] = in_sample_2;
    samples[3] = in_sample_3;
    samples[4] = in_sample_4;
    samples[5] = in_sample_5;
    samples[6] = in_sample_6;
    samples[7] = in_sample_7;
  end

  // Controller: accept a word only in idle. A calibration word widens the
  // extremes at capture and the controller stays idle. A frame word runs
  // load, lane divide, sum and centroid divide, then waits until the output
  // register is free before loading it. A result word already waiting does
  // not stop a new frame from being taken and computed, but while the
  // controller holds in done for a stalled result the input stays stalled.
  lscs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_calibrate (in_calibrate),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  // Datapath: the per-lane extremes, one restoring divider per lane giving
  // the 0..100 percent scale, the weighted and plain sums, the centroid
  // divider and the table lookup into the output register.
  lscs_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .samples       (samples),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .line_position (out_line_position),
    .left_drive    (out_left_drive),
    .right_drive   (out_right_drive),
    .no_line       (out_no_line)
  );

endmodule

### sim/centroid_steer_checker.sv
// ----------------------------------------------------------------------------
// centroid_steer_checker: steering word predictor and scoreboard
// Tracks the per-lane extremes and both drive tables from the traffic it
// watches, predicts one steering word per accepted non-calibration frame and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module centroid_steer_checker (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_valid,
  input  logic                                                  in_stall,
  input  logic                                                  in_calibrate,
  input  logic [lscs_pkg::LANES_MAX-1:0][lscs_pkg::SAMPLE_W-1:0] in_frame,
  input  logic                                                  out_valid,
  input  logic                                                  out_stall,
  input  logic [lscs_pkg::POS_W-1:0]                            out_line_position,
  input  logic [lscs_pkg::DRIVE_W-1:0]                          out_left_drive,
  input  logic [lscs_pkg::DRIVE_W-1:0]                          out_right_drive,
  input  logic                                                  out_no_line,
  input  logic                                                  cfg_we,
  input  logic [lscs_pkg::CFG_IDX_W-1:0]                        cfg_index,
  input  logic [lscs_pkg::CFG_W-1:0]                            cfg_wdata,
  output int unsigned                                           fail_count,
  output int unsigned                                           steer_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lscs_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [DRIVE_W-1:0] left;
    logic [DRIVE_W-1:0] right;
    logic               no_line;
  } steer_word_t;

  logic [SAMPLE_W-1:0] lane_peak  [LANES_MAX];
  logic [SAMPLE_W-1:0] lane_floor [LANES_MAX];
  logic [CFG_W-1:0]    left_table;
  logic [CFG_W-1:0]    right_table;
  steer_word_t         expected_steer [$];
  int unsigned         miscount = 0;

  assign fail_count = miscount;

  // Widen the extremes with one frame and work out the steering word it gives.
  function automatic steer_word_t predict_steer(input logic [LANES_MAX-1:0][SAMPLE_W-1:0] frame);
    steer_word_t w;
    logic [SAMPLE_W-1:0] s;
    int unsigned span, scaled, total, weighted, pos, sel;
    total    = 0;
    weighted = 0;
    for (int k = 0; k < LANES_MAX; k++) begin
      s = frame[k];
      if (s > lane_peak[k]) lane_peak[k] = s;
      if (s < lane_floor[k]) lane_floor[k] = s;
      span = 32'(lane_peak[k]) - 32'(lane_floor[k]);
      // a flat lane (peak equals floor) contributes nothing
      if (span == 0 || s < lane_floor[k]) begin
        scaled = 0;
      end else begin
        scaled = ((32'(s) - 32'(lane_floor[k])) * FULL_SCALE) / span;
        if (scaled > FULL_SCALE) scaled = FULL_SCALE;
      end
      total    += scaled;
      weighted += (k + 1) * scaled;
    end
    // no line: position 0 and table entry 0
    pos = (total == 0) ? 0 : weighted / total;
    // position 8 still reads the last table entry
    sel = (pos > 32'(TABLE_TOP)) ? 32'(TABLE_TOP) : pos;
    w.position = POS_W'(pos);
    w.left     = left_table[8*sel +: 8];
    w.right    = right_table[8*sel +: 8];
    w.no_line  = (total == 0);
    return w;
  endfunction

  function automatic void note_failure(input string what);
    if (miscount < REPORT_MAX) $display("%0t ns: %s", $time, what);
    miscount++;
  endfunction

  always @(posedge clk) begin
    steer_word_t seen, want;
    if (!rst_n) begin
      for (int k = 0; k < LANES_MAX; k++) begin
        lane_peak[k]  = '0;
        lane_floor[k] = '1;
      end
      left_table  = LEFT_RESET;
      right_table = RIGHT_RESET;
      expected_steer.delete();
      steer_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LEFT) left_table = cfg_wdata;
        else if (cfg_index == REG_RIGHT) right_table = cfg_wdata;
      end
      // check the outgoing word first: it never belongs to a frame taken now
      if (out_valid && !out_stall) begin
        seen = '{out_line_position, out_left_drive, out_right_drive, out_no_line};
        if (expected_steer.size() == 0) begin
          note_failure($sformatf("unexpected steer word: pos %0d left %02h right %02h no_line %0b",
                                 seen.position, seen.left, seen.right, seen.no_line));
        end else begin
          want = expected_steer.pop_front();
          if (seen.position !== want.position || seen.left !== want.left ||
              seen.right !== want.right || seen.no_line !== want.no_line)
            note_failure($sformatf({"steer mismatch: expected pos %0d left %02h right %02h ",
                                    "no_line %0b, got pos %0d left %02h right %02h no_line %0b"},
                                   want.position, want.left, want.right, want.no_line,
                                   seen.position, seen.left, seen.right, seen.no_line));
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_steer(in_frame);
        if (!in_calibrate) expected_steer.push_back(want);
      end
      steer_pending <= expected_steer.size();
    end
  end

endmodule

### sim/line_sensor_centroid_steer_unit_test.sv
// ----------------------------------------------------------------------------
// line_sensor_centroid_steer_unit_test: frame stimulus and verdict
// Drives sensor frames through the unit: a short directed sweep over the
// scaling and centroid corner cases, then phases of random line-shaped,
// flat, noisy and calibration frames, with new drive tables between phases.
// Both channels idle at random; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module line_sensor_centroid_steer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lscs_pkg::*;

  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned IDLE_PCT      = 6;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_FRAMES  = 160;
  // margin after the last result for a busy unit
  localparam int unsigned SETTLE_CYCLES = 24;
  // covers a frame's processing plus the longest sender gap, receiver stall and
  // settle pause, taken several times over
  localparam int unsigned STALL_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               in_calibrate = 1'b0;
  logic [LANES_MAX-1:0][SAMPLE_W-1:0] in_samples = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [POS_W-1:0]                   out_line_position;
  logic [DRIVE_W-1:0]                 out_left_drive;
  logic [DRIVE_W-1:0]                 out_right_drive;
  logic                               out_no_line;
  logic                               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]               cfg_index = '0;
  logic [CFG_W-1:0]                   cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned steer_pending;
  int unsigned quiet_cycles = 0;
  bit          quiet_phase = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_sensor_centroid_steer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_calibrate      (in_calibrate),
    .in_sample_0       (in_samples[0]),
    .in_sample_1       (in_samples[1]),
    .in_sample_2       (in_samples[2]),
    .in_sample_3       (in_samples[3]),
    .in_sample_4       (in_samples[4]),
    .in_sample_5       (in_samples[5]),
    .in_sample_6       (in_samples[6]),
    .in_sample_7       (in_samples[7]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_position (out_line_position),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_no_line       (out_no_line),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  centroid_steer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_calibrate      (in_calibrate),
    .in_frame          (in_samples),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_position (out_line_position),
    .out_left_drive    (out_left_drive),
    .out_right_drive   (out_right_drive),
    .out_no_line       (out_no_line),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .steer_pending     (steer_pending)
  );

  // Receiver back-pressure: stall now and then, never in the quiet phase.
  always @(posedge clk) begin
    out_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("line_sensor_centroid_steer_unit test failed");
      $finish;
    end
  end

  // Offer one frame word, idling first at random, and hold it until taken.
  task automatic send_frame(input bit calib, input logic [CFG_W-1:0] frame);
    while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_calibrate <= calib;
    in_samples   <= frame;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Drop valid and wait until every predicted word is out, then let the
  // unit finish whatever calibration word it may still hold.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (steer_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_tables(input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] right);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEFT;
    cfg_wdata <= left;
    @(posedge clk);
    cfg_index <= REG_RIGHT;
    cfg_wdata <= right;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] frame;
    logic [CFG_W-1:0] left, right;
    int unsigned      kind, bg, center, width;
    bit               calib;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweep with the reset drive tables.
    send_frame(1'b0, 64'h0000_0000_0000_0000);  // fresh extremes: every lane flat
    send_frame(1'b1, 64'h6464_6464_6464_6464);  // calibrate: spans become 0..100
    send_frame(1'b0, 64'h3232_3232_3232_3232);  // all at half scale: center
    send_frame(1'b0, 64'h0000_0000_0000_0064);  // line under lane 0: position 1
    send_frame(1'b0, 64'h6400_0000_0000_0000);  // line under lane 7: position 8
    send_frame(1'b0, 64'h0000_0000_0000_0000);  // all at floor: no line
    send_frame(1'b0, 64'h6464_0000_0000_0000);  // lanes 6 and 7: position 7
    send_frame(1'b1, 64'hC8FF_C8FF_C8FF_C8FF);  // calibrate: uneven peaks
    send_frame(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);  // widen every span to full
    send_frame(1'b0, 64'h55AA_55AA_55AA_55AA);
    send_frame(1'b0, 64'hAA55_AA55_AA55_AA55);
    send_frame(1'b0, 64'h0000_0000_0100_0000);  // scales to zero: no line
    send_frame(1'b0, 64'h0000_0000_0300_0000);  // smallest nonzero scaled value
    send_frame(1'b0, 64'hFF00_0000_0000_00FF);  // both edges lit
    send_frame(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);  // calibrate with no change
    send_frame(1'b0, 64'h8080_8080_8080_8000);  // lanes 1..7 at half
    send_frame(1'b0, 64'h7F01_FE80_10EF_C033);

    // Random phases, each with its own drive tables; the pause before each
    // table load lets the unit drain completely.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      unique case (p)
        0: begin left = '0; right = '1; end
        1: begin left = '1; right = '0; end
        default: begin
          left  = {$urandom, $urandom};
          right = {$urandom, $urandom};
        end
      endcase
      load_tables(left, right);
      // hold both sides busy for one whole phase
      quiet_phase = (p == 2);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        kind  = $urandom_range(99);
        calib = 1'b0;
        if (kind < 12) begin
          calib = 1'b1;
          frame = {$urandom, $urandom};
        end else if (kind < 20) begin
          frame = {$urandom, $urandom};
        end else if (kind < 28) begin
          // flat frame, often at the floor
          bg = $urandom_range(1) ? 0 : $urandom_range(255);
          frame = {LANES_MAX{8'(bg)}};
        end else begin
          // dark background with a bright line a few lanes wide
          bg     = $urandom_range(40);
          center = $urandom_range(LANES_MAX - 1);
          width  = $urandom_range(2);
          for (int k = 0; k < LANES_MAX; k++) begin
            if (k + width >= center && k <= center + width)
              frame[8*k +: 8] = 8'($urandom_range(255, 140));
            else
              frame[8*k +: 8] = 8'(bg + $urandom_range(15));
          end
        end
        send_frame(calib, frame);
      end
      quiet_phase = 1'b0;
    end

    settle();
    if (fail_count == 0 && steer_pending == 0) begin
      $display("line_sensor_centroid_steer_unit test passed");
    end else begin
      $display("line_sensor_centroid_steer_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lscs_pkg.sv
hdl/lscs_ctrl.sv
hdl/lscs_datapath.sv
hdl/line_sensor_centroid_steer_unit.sv
sim/centroid_steer_checker.sv
sim/line_sensor_centroid_steer_unit_test.sv
